### src/fbr_pkg.sv
// Shared types and constants for the framed byte receiver.
// Has no dependencies; every other file of the block imports it.
package fbr_pkg;

  localparam logic [7:0]  START_BYTE    = 8'h7E;
  localparam logic [15:0] TIMEOUT_RESET = 16'd50;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_TYPE    = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    K_PAYLOAD = 2'd0,
    K_GOOD    = 2'd1,
    K_BAD     = 2'd2,
    K_TIMEOUT = 2'd3
  } kind_e;

  typedef enum logic {
    MODE_BYTE = 1'b0,
    MODE_TICK = 1'b1
  } mode_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload_data;
    logic [7:0] payload_index;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
  } result_t;

endpackage

### src/fbr_parser.sv
// Frame parser: phase, running checksum and tick counter, updated once per transaction.
// Depends on fbr_pkg; produces at most one result per accepted transaction.
module fbr_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             mode_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i,
  output logic             res_valid_o,
  output fbr_pkg::result_t res_o
);
  import fbr_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  length_q, length_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  xor_q, xor_d;
  logic [15:0] idle_q, idle_d;
  logic [15:0] timeout_q;
  logic [7:0]  pos_inc;
  logic        in_frame;

  assign pos_inc  = pos_q + 8'd1;
  assign in_frame = (phase_q == PH_LENGTH) || (phase_q == PH_TYPE) ||
                    (phase_q == PH_PAYLOAD) || (phase_q == PH_CHECK);

  always_comb begin
    phase_d     = phase_q;
    length_d    = length_q;
    type_d      = type_q;
    pos_d       = pos_q;
    xor_d       = xor_q;
    idle_d      = idle_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: K_PAYLOAD, default: '0};
    if (accept_i) begin
      if (mode_e'(mode_i) == MODE_TICK) begin
        if (idle_q != 16'hFFFF) begin
          idle_d = idle_q + 16'd1;
        end
      end else if (in_frame && (idle_q > timeout_q)) begin
        phase_d       = PH_START;
        res_valid_o   = 1'b1;
        res_o.kind    = K_TIMEOUT;
      end else begin
        idle_d = '0;
        unique case (phase_q)
          PH_LENGTH: begin
            length_d = rx_byte_i;
            pos_d    = '0;
            phase_d  = PH_TYPE;
          end
          PH_TYPE: begin
            type_d  = rx_byte_i;
            xor_d   = rx_byte_i;
            phase_d = (length_q != 8'd0) ? PH_PAYLOAD : PH_CHECK;
          end
          PH_PAYLOAD: begin
            xor_d               = xor_q ^ rx_byte_i;
            pos_d               = pos_inc;
            phase_d             = (pos_inc >= length_q) ? PH_CHECK : PH_PAYLOAD;
            res_valid_o         = 1'b1;
            res_o.kind          = K_PAYLOAD;
            res_o.payload_data  = rx_byte_i;
            res_o.payload_index = pos_q;
          end
          PH_CHECK: begin
            phase_d            = PH_START;
            res_valid_o        = 1'b1;
            res_o.kind         = (xor_q == rx_byte_i) ? K_GOOD : K_BAD;
            res_o.frame_type   = type_q;
            res_o.frame_length = length_q;
          end
          default: begin
            phase_d = (rx_byte_i == START_BYTE) ? PH_LENGTH : PH_START;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      length_q  <= '0;
      type_q    <= '0;
      pos_q     <= '0;
      xor_q     <= '0;
      idle_q    <= '0;
      timeout_q <= TIMEOUT_RESET;
    end else begin
      phase_q  <= phase_d;
      length_q <= length_d;
      type_q   <= type_d;
      pos_q    <= pos_d;
      xor_q    <= xor_d;
      idle_q   <= idle_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

endmodule

### src/fbr_out_buf.sv
// Output register with a skid entry; the input side waits only while both are full.
// Depends on fbr_pkg for the result struct.
module fbr_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fbr_pkg::result_t push_data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fbr_pkg::result_t out_data_o
);
  import fbr_pkg::*;

  logic    main_valid_q;
  logic    skid_valid_q;
  result_t main_q;
  result_t skid_q;
  logic    pop;

  assign pop         = main_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (main_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end else if (pop) begin
      main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (main_valid_q && !pop) begin
        skid_q <= push_data_i;
      end else begin
        main_q <= push_data_i;
      end
    end
  end

endmodule

### src/framed_byte_receiver_core.sv
// Framed byte receiver: parses start byte, length, type, payload and XOR checksum.
// Each result is registered in the output register, or first in the skid entry under stall.
// Throughput is one transaction per cycle unless stalled; the parser updates in one pass.
// The input stalls only while the output register and its skid entry are both full.
// Reset clears the parser to hunting for the start byte and sets the timeout to 50 ticks.
module framed_byte_receiver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_data_o,
  output logic [7:0]  payload_index_o,
  output logic [7:0]  frame_type_o,
  output logic [7:0]  frame_length_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import fbr_pkg::*;

  logic    accept;
  logic    res_valid;
  logic    buf_full;
  result_t res;
  result_t out_data;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  fbr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .mode_i      (mode_i),
    .rx_byte_i   (rx_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fbr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign kind_o          = out_data.kind;
  assign payload_data_o  = out_data.payload_data;
  assign payload_index_o = out_data.payload_index;
  assign frame_type_o    = out_data.frame_type;
  assign frame_length_o  = out_data.frame_length;

endmodule

### bench/framed_byte_receiver_core_test.sv
// Self-checking testbench for framed_byte_receiver_core: directed frames, then random
// frames, noise, ticks and timeout settings; results checked against script or predictor.
// Depends on fbr_pkg and framed_byte_receiver_core only.
module framed_byte_receiver_core_test;
  import fbr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned ITEMS_PER_SETTING = 310;
  localparam result_t     NO_RES = '0;

  typedef enum logic [1:0] {
    CHK_PREDICT = 2'd0,
    CHK_SILENT  = 2'd1,
    CHK_TYPED   = 2'd2
  } row_check_e;

  typedef struct packed {
    mode_e      m;
    logic [7:0] b;
    logic [7:0] reps;
    row_check_e chk;
    result_t    want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        mode_i;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [7:0]  payload_data_o;
  logic [7:0]  payload_index_o;
  logic [7:0]  frame_type_o;
  logic [7:0]  frame_length_o;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  row_check_e  row_check;
  result_t     row_want;
  result_t     pending_results[$];
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  bit          steady = 1'b0;
  logic [15:0] timeout_now = TIMEOUT_RESET;

  phase_e      rx_phase = PH_START;
  logic [7:0]  rx_len = '0;
  logic [7:0]  rx_type = '0;
  logic [7:0]  rx_pos = '0;
  logic [7:0]  rx_xor = '0;
  logic [15:0] rx_idle = '0;
  logic [15:0] rx_timeout = TIMEOUT_RESET;

  stim_row_t script [27] = '{
    {MODE_TICK, 8'h00, 8'd1,  CHK_SILENT, NO_RES},
    {MODE_BYTE, 8'h00, 8'd1,  CHK_SILENT, NO_RES},
    {MODE_BYTE, 8'hFF, 8'd1,  CHK_SILENT, NO_RES},
    {MODE_BYTE, 8'h7E, 8'd1,  CHK_SILENT, NO_RES},
    {MODE_BYTE, 8'h03, 8'd1,  CHK_SILENT, NO_RES},
    {MODE_BYTE, 8'hFF, 8'd1,  CHK_SILENT, NO_RES},
    {MODE_BYTE, 8'h00, 8'd1,  CHK_TYPED,  {K_PAYLOAD, 8'h00, 8'd0, 8'h00, 8'd0}},
    {MODE_BYTE, 8'hFF, 8'd1,  CHK_TYPED,  {K_PAYLOAD, 8'hFF, 8'd1, 8'h00, 8'd0}},
    {MODE_BYTE, 8'h5A, 8'd1,  CHK_TYPED,  {K_PAYLOAD, 8'h5A, 8'd2, 8'h00, 8'd0}},
    {MODE_BYTE, 8'h5A, 8'd1,  CHK_TYPED,  {K_GOOD,    8'h00, 8'd0, 8'hFF, 8'd3}},
    {MODE_BYTE, 8'h7E, 8'd1,  CHK_SILENT, NO_RES},
    {MODE_BYTE, 8'h00, 8'd1,  CHK_SILENT, NO_RES},
    {MODE_BYTE, 8'h00, 8'd1,  CHK_SILENT, NO_RES},
    {MODE_BYTE, 8'h01, 8'd1,  CHK_TYPED,  {K_BAD,     8'h00, 8'd0, 8'h00, 8'd0}},
    {MODE_BYTE, 8'h7E, 8'd1,  CHK_SILENT, NO_RES},
    {MODE_BYTE, 8'hFF, 8'd1,  CHK_SILENT, NO_RES},
    {MODE_BYTE, 8'h81, 8'd1,  CHK_SILENT, NO_RES},
    {MODE_BYTE, 8'h11, 8'd1,  CHK_TYPED,  {K_PAYLOAD, 8'h11, 8'd0, 8'h00, 8'd0}},
    {MODE_TICK, 8'hA5, 8'd51, CHK_SILENT, NO_RES},
    {MODE_BYTE, 8'h22, 8'd1,  CHK_TYPED,  {K_TIMEOUT, 8'h00, 8'd0, 8'h00, 8'd0}},
    {MODE_BYTE, 8'h7E, 8'd1,  CHK_SILENT, NO_RES},
    {MODE_TICK, 8'h5A, 8'd50, CHK_SILENT, NO_RES},
    {MODE_BYTE, 8'h02, 8'd1,  CHK_SILENT, NO_RES},
    {MODE_BYTE, 8'hC3, 8'd1,  CHK_SILENT, NO_RES},
    {MODE_BYTE, 8'h7E, 8'd1,  CHK_PREDICT, NO_RES},
    {MODE_BYTE, 8'hA5, 8'd1,  CHK_PREDICT, NO_RES},
    {MODE_BYTE, 8'h66, 8'd1,  CHK_PREDICT, NO_RES}
  };

  framed_byte_receiver_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .payload_data_o  (payload_data_o),
    .payload_index_o (payload_index_o),
    .frame_type_o    (frame_type_o),
    .frame_length_o  (frame_length_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic bit frame_step(input mode_e m, input logic [7:0] b, output result_t r);
    r = '0;
    if (m == MODE_TICK) begin
      if (rx_idle != 16'hFFFF) rx_idle = rx_idle + 16'd1;
      return 1'b0;
    end
    if (rx_phase != PH_START && rx_idle > rx_timeout) begin
      rx_phase = PH_START;
      r.kind = K_TIMEOUT;
      return 1'b1;
    end
    rx_idle = '0;
    case (rx_phase)
      PH_LENGTH: begin
        rx_len = b;
        rx_pos = '0;
        rx_phase = PH_TYPE;
      end
      PH_TYPE: begin
        rx_type = b;
        rx_xor = b;
        rx_phase = (rx_len != 8'd0) ? PH_PAYLOAD : PH_CHECK;
      end
      PH_PAYLOAD: begin
        r.kind = K_PAYLOAD;
        r.payload_data = b;
        r.payload_index = rx_pos;
        rx_xor = rx_xor ^ b;
        rx_pos = rx_pos + 8'd1;
        if (rx_pos >= rx_len) rx_phase = PH_CHECK;
        return 1'b1;
      end
      PH_CHECK: begin
        r.kind = (rx_xor == b) ? K_GOOD : K_BAD;
        r.frame_type = rx_type;
        r.frame_length = rx_len;
        rx_phase = PH_START;
        return 1'b1;
      end
      default: begin
        rx_phase = (b == START_BYTE) ? PH_LENGTH : PH_START;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void check_field(input string what, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i) begin : scoreboard
    result_t want;
    result_t predicted;
    bit      made;
    if (out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual kind %0d",
                 $time, kind_o);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", {6'd0, want.kind}, {6'd0, kind_o});
        check_field("payload_data", want.payload_data, payload_data_o);
        check_field("payload_index", want.payload_index, payload_index_o);
        check_field("frame_type", want.frame_type, frame_type_o);
        check_field("frame_length", want.frame_length, frame_length_o);
      end
    end
    if (cfg_we_i) rx_timeout = cfg_wdata_i;
    if (in_valid_i && !in_stall_o) begin
      made = frame_step(mode_e'(mode_i), rx_byte_i, predicted);
      if (row_check == CHK_TYPED) pending_results.push_back(row_want);
      else if (row_check == CHK_PREDICT && made) pending_results.push_back(predicted);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin : out_pacing
    int free_cycles;
    int stall_cycles;
    out_stall_i <= 1'b0;
    forever begin
      if ($urandom_range(0, 9) == 0) free_cycles = $urandom_range(40, 200);
      else free_cycles = $urandom_range(1, 6);
      repeat (free_cycles) @(posedge clk_i);
      stall_cycles = pick_gap();
      if (stall_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_cycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_item(input mode_e m, input logic [7:0] b, input row_check_e chk,
                           input result_t want);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    rx_byte_i <= b;
    row_check <= chk;
    row_want <= want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    send_item(MODE_BYTE, b, CHK_PREDICT, NO_RES);
  endtask

  task automatic put_ticks(input int n);
    repeat (n) send_item(MODE_TICK, 8'($urandom_range(0, 255)), CHK_PREDICT, NO_RES);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    timeout_now = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Long frames see long tick gaps only rarely so that they can reach high indexes.
  task automatic gap_ticks(input bit long_frame);
    int r;
    r = $urandom_range(0, long_frame ? 1999 : 99);
    if (r < 5 && timeout_now <= 16'd1000) put_ticks(timeout_now + $urandom_range(0, 2));
    else if (r < 20) put_ticks($urandom_range(1, 3));
  endtask

  task automatic random_frame();
    int         shape;
    int         len;
    int         cut;
    int         k;
    bit         long_frame;
    logic [7:0] ty;
    logic [7:0] sum;
    logic [7:0] b;
    shape = $urandom_range(0, 99);
    steady = ($urandom_range(0, 7) == 0);
    if (shape >= 85) begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 2) == 0) put_ticks($urandom_range(1, 4));
        else put_byte(8'($urandom_range(0, 255)));
      end
    end else begin
      long_frame = ($urandom_range(0, 19) == 0);
      len = long_frame ? $urandom_range(100, 255) : $urandom_range(0, 8);
      cut = (shape >= 70) ? $urandom_range(0, len + 2) : len + 3;
      ty = 8'($urandom_range(0, 255));
      sum = ty;
      put_byte(START_BYTE);
      for (k = 0; k < cut; k++) begin
        if (k == 0) b = len[7:0];
        else if (k == 1) b = ty;
        else if (k < len + 2) begin
          b = 8'($urandom_range(0, 255));
          sum = sum ^ b;
        end else if ($urandom_range(0, 4) == 0) b = 8'($urandom_range(0, 255));
        else b = sum;
        gap_ticks(long_frame);
        put_byte(b);
      end
    end
  endtask

  initial begin : stimulus
    int unsigned first_item;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    mode_i <= MODE_BYTE;
    rx_byte_i <= 8'h00;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= 16'h0000;
    row_check <= CHK_PREDICT;
    row_want <= NO_RES;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      repeat (script[i].reps) send_item(script[i].m, script[i].b, script[i].chk, script[i].want);
    end

    for (int s = 0; s < 5; s++) begin
      case (s)
        0: write_timeout(TIMEOUT_RESET);
        1: write_timeout(16'd0);
        2: write_timeout(16'd3);
        3: write_timeout(16'hFFFF);
        default: write_timeout(16'($urandom_range(1, 40)));
      endcase
      first_item = items_sent;
      while (items_sent - first_item < ITEMS_PER_SETTING) random_frame();
    end

    settle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
